### hw/rtl/tfda_pkg.sv
// Shared types and constants for the thermocouple fault debounce and average block.
`timescale 1ns / 1ps

package tfda_pkg;

    // Default averaging window depth
    localparam int WINDOW_DEF = 4;

    // Payload widths
    localparam int TEMP_W = 14;
    localparam int THR_W  = 8;
    localparam int FB_W   = 3;

    // Fault threshold after reset
    localparam logic [THR_W-1:0] THR_RESET = 8'd3;

    // Saturation value of the fault counter
    localparam logic [THR_W-1:0] FCNT_MAX = 8'd255;

    // Fault bit positions
    localparam int FB_OPEN      = 0;
    localparam int FB_SHORT_GND = 1;
    localparam int FB_SHORT_VCC = 2;

    // Channel error codes
    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_UNKNOWN   = 3'd1,
        ERR_OPEN      = 3'd2,
        ERR_SHORT_GND = 3'd3,
        ERR_SHORT_VCC = 3'd4
    } error_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_FIX,
        S_DONE
    } state_t;

endpackage

### hw/rtl/thermocouple_fault_debounce_average.sv
// Two-channel thermocouple front end: fault debounce and running average.
`timescale 1ns / 1ps

// Each input word is one conversion for channel 0 (exhaust) or 1 (bean) and
// yields exactly one result word. A good sample enters a WINDOW-deep ring per
// channel; the reading is the ring sum divided by the fill count, rounded
// toward negative infinity. A failed sample bumps a saturating per-channel
// fault counter; at or past fault_threshold the fault is classified (open,
// short to ground, short to VCC, else unknown) and the reading goes invalid.
// A good sample is evaluated, then runs through the bit-serial restoring
// divider, which produces one quotient bit per cycle, and a floor correction;
// a failed sample skips the divider and the correction. in_stall is high
// while a word is in progress. A finished result sits in the output register
// and the next input word is accepted while it waits. fault_threshold is
// written through the cfg port, which is always ready; write it only while
// the block is idle.
module thermocouple_fault_debounce_average
    import tfda_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,

    // Configuration write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [THR_W-1:0]         cfg_data,

    // Input channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     channel,
    input  logic                     sample_ok,
    input  logic signed [TEMP_W-1:0] temperature_q,
    input  logic [FB_W-1:0]          fault_bits,

    // Output channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     out_channel,
    output logic signed [TEMP_W-1:0] reading_q,
    output logic                     reading_valid,
    output logic                     reading_changed,
    output logic [2:0]               error_code,
    output logic                     resync_request,
    output logic                     bus_reinit
);

    localparam int SUM_W     = TEMP_W + $clog2(WINDOW);
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int POS_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SLOT_W    = $clog2(2 * WINDOW);
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    localparam logic [CNT_W-1:0]     FILL_FULL = CNT_W'(WINDOW);
    localparam logic [POS_W-1:0]     POS_LAST  = POS_W'(WINDOW - 1);
    localparam logic [SLOT_W-1:0]    CH1_BASE  = SLOT_W'(WINDOW);
    localparam logic [DIV_CNT_W-1:0] DIV_LEN   = DIV_CNT_W'(SUM_W);

    // Sequencer
    state_t state_reg, state_next;

    // Configuration
    logic [THR_W-1:0] thr_reg;

    // Captured input word
    logic                     ch_reg;
    logic                     ok_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic [FB_W-1:0]          fb_reg;

    // Per-channel state
    logic signed [SUM_W-1:0]  sum_reg      [2];
    logic [CNT_W-1:0]         fill_reg     [2];
    logic [POS_W-1:0]         pos_reg      [2];
    logic [THR_W-1:0]         fcnt_reg     [2];
    error_t                   err_reg      [2];
    logic signed [TEMP_W-1:0] last_reg     [2];
    logic                     last_vld_reg [2];

    // Sample ring, channel 0 entries first
    logic signed [TEMP_W-1:0] ring_mem [2*WINDOW];
    logic signed [TEMP_W-1:0] ring_rd_reg;

    // Shared divider
    logic [SUM_W-1:0]     quo_reg;
    logic [CNT_W:0]       rem_reg;
    logic [CNT_W-1:0]     den_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // Per-word result flags
    logic changed_reg;
    logic resync_reg;
    logic reinit_reg;

    // Output register
    logic                     out_valid_reg;
    logic                     out_ch_reg;
    logic signed [TEMP_W-1:0] out_reading_reg;
    logic                     out_rvalid_reg;
    logic                     out_changed_reg;
    error_t                   out_err_reg;
    logic                     out_resync_reg;
    logic                     out_reinit_reg;

    logic in_accept;
    logic out_load;

    // Good-sample datapath
    logic [SLOT_W-1:0]       in_slot;
    logic [SLOT_W-1:0]       slot;
    logic                    ring_full;
    logic signed [SUM_W-1:0] old_ext;
    logic signed [SUM_W-1:0] temp_ext;
    logic signed [SUM_W-1:0] sum_new;
    logic [SUM_W-1:0]        sum_abs;
    logic [CNT_W-1:0]        fill_new;
    logic [POS_W-1:0]        pos_new;

    // Failed-sample datapath
    logic [THR_W-1:0] fcnt_inc;
    logic             declared;
    logic             other_hit;
    logic             reinit_hit;
    error_t           err_class;

    // Divider step and final correction
    logic [CNT_W:0]          rem_shift;
    logic                    rem_ge;
    logic [CNT_W:0]          rem_sub;
    logic [SUM_W-1:0]        quo_corr;
    logic [SUM_W-1:0]        quo_signed;

    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && !in_stall;

    // Locate the ring slot and form the new running sum
    assign in_slot   = (channel ? CH1_BASE : '0) + SLOT_W'(pos_reg[channel]);
    assign slot      = (ch_reg ? CH1_BASE : '0) + SLOT_W'(pos_reg[ch_reg]);
    assign ring_full = (fill_reg[ch_reg] == FILL_FULL);
    assign old_ext   = ring_full ? SUM_W'(ring_rd_reg) : '0;
    assign temp_ext  = SUM_W'(temp_reg);
    assign sum_new   = sum_reg[ch_reg] - old_ext + temp_ext;
    assign sum_abs   = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
    assign fill_new  = ring_full ? fill_reg[ch_reg] : fill_reg[ch_reg] + CNT_W'(1);
    assign pos_new   = (pos_reg[ch_reg] == POS_LAST) ? '0 : pos_reg[ch_reg] + POS_W'(1);

    // Debounce the failure and classify it
    assign fcnt_inc   = (fcnt_reg[ch_reg] == FCNT_MAX) ? FCNT_MAX
                                                       : fcnt_reg[ch_reg] + THR_W'(1);
    assign declared   = (fcnt_inc >= thr_reg);
    assign other_hit  = (fcnt_reg[~ch_reg] >= thr_reg);
    assign reinit_hit = declared && fb_reg[FB_SHORT_GND] && other_hit;

    always_comb
    begin
        priority if (fb_reg[FB_OPEN])
            err_class = ERR_OPEN;
        else if (fb_reg[FB_SHORT_GND])
            err_class = ERR_SHORT_GND;
        else if (fb_reg[FB_SHORT_VCC])
            err_class = ERR_SHORT_VCC;
        else
            err_class = ERR_UNKNOWN;
    end

    // One restoring-division step, then floor correction for negative sums
    assign rem_shift  = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
    assign rem_ge     = (rem_shift >= {1'b0, den_reg});
    assign rem_sub    = rem_shift - {1'b0, den_reg};
    assign quo_corr   = quo_reg + SUM_W'(neg_reg && (rem_reg != '0));
    assign quo_signed = neg_reg ? SUM_W'(-quo_corr) : quo_corr;

    // Next state and handshake outputs
    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = ok_reg ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                if (div_cnt_reg == DIV_CNT_W'(1))
                    state_next = S_FIX;
            end
            S_FIX:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Hold the fault threshold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_valid && cfg_ready)
            thr_reg <= cfg_data;
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ch_reg   <= channel;
            ok_reg   <= sample_ok;
            temp_reg <= temperature_q;
            fb_reg   <= fault_bits;
        end
    end

    // Fetch the oldest sample on accept, write the new sample into the ring
    always_ff @(posedge clk)
    begin
        if (in_accept)
            ring_rd_reg <= ring_mem[in_slot];
        if (state_reg == S_EVAL && ok_reg)
            ring_mem[slot] <= temp_reg;
    end

    // Update per-channel state and result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                sum_reg[i]      <= '0;
                fill_reg[i]     <= '0;
                pos_reg[i]      <= '0;
                fcnt_reg[i]     <= '0;
                err_reg[i]      <= ERR_OK;
                last_reg[i]     <= '0;
                last_vld_reg[i] <= 1'b1;
            end
            changed_reg <= 1'b0;
            resync_reg  <= 1'b0;
            reinit_reg  <= 1'b0;
        end
        else if (state_reg == S_EVAL)
        begin
            if (ok_reg)
            begin
                sum_reg[ch_reg]  <= sum_new;
                fill_reg[ch_reg] <= fill_new;
                pos_reg[ch_reg]  <= pos_new;
                fcnt_reg[ch_reg] <= '0;
                err_reg[ch_reg]  <= ERR_OK;
                changed_reg      <= 1'b1;
                resync_reg       <= 1'b0;
                reinit_reg       <= 1'b0;
            end
            else
            begin
                changed_reg <= declared;
                resync_reg  <= declared && (fb_reg == '0);
                reinit_reg  <= reinit_hit;
                if (reinit_hit)
                begin
                    fcnt_reg[0] <= '0;
                    fcnt_reg[1] <= '0;
                end
                else
                begin
                    fcnt_reg[ch_reg] <= fcnt_inc;
                end
                if (declared)
                begin
                    err_reg[ch_reg]      <= err_class;
                    last_reg[ch_reg]     <= '0;
                    last_vld_reg[ch_reg] <= 1'b0;
                end
            end
        end
        else if (state_reg == S_FIX)
        begin
            last_reg[ch_reg]     <= TEMP_W'(quo_signed);
            last_vld_reg[ch_reg] <= 1'b1;
        end
    end

    // Load and advance the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (state_reg == S_EVAL)
            div_cnt_reg <= DIV_LEN;
        else if (state_reg == S_DIV)
            div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EVAL)
        begin
            quo_reg <= sum_abs;
            rem_reg <= '0;
            den_reg <= fill_new;
            neg_reg <= sum_new[SUM_W-1];
        end
        else if (state_reg == S_DIV)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_sub : rem_shift;
        end
    end

    // Output register: hold the word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ch_reg      <= ch_reg;
            out_reading_reg <= last_reg[ch_reg];
            out_rvalid_reg  <= last_vld_reg[ch_reg];
            out_changed_reg <= changed_reg;
            out_err_reg     <= err_reg[ch_reg];
            out_resync_reg  <= resync_reg;
            out_reinit_reg  <= reinit_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_channel     = out_ch_reg;
    assign reading_q       = out_reading_reg;
    assign reading_valid   = out_rvalid_reg;
    assign reading_changed = out_changed_reg;
    assign error_code      = out_err_reg;
    assign resync_request  = out_resync_reg;
    assign bus_reinit      = out_reinit_reg;

endmodule
